### rtl/tcpq_pkg.sv
// ----------------------------------------------------------------------------
// tcpq_pkg
// Shared types and codes of the two-class priority packet queue.
// ----------------------------------------------------------------------------
package tcpq_pkg;

    localparam int ID_W    = 16;
    localparam int BYTES_W = 14;
    localparam int TOTAL_W = 24;
    localparam int DROP_W  = 32;
    localparam int ENTRY_W = ID_W + BYTES_W;

    localparam logic [TOTAL_W-1:0] TOTAL_MAX     = '1;
    localparam logic [TOTAL_W-1:0] LIMIT_RESET   = 24'h010000;

    // Depth of the queue between front and back.
    localparam int FQ_DEPTH = 2;

    // Command codes
    localparam logic CMD_ARRIVE   = 1'b0;
    localparam logic CMD_COMPLETE = 1'b1;

    // Packet kinds
    localparam logic [3:0] KIND_TCP      = 4'd0;
    localparam logic [3:0] KIND_TCPACK   = 4'd1;
    localparam logic [3:0] KIND_IP       = 4'd2;
    localparam logic [3:0] KIND_TRIM     = 4'd3;
    localparam logic [3:0] KIND_ACK      = 4'd4;
    localparam logic [3:0] KIND_NACK     = 4'd5;
    localparam logic [3:0] KIND_PULL     = 4'd6;
    localparam logic [3:0] KIND_LITE     = 4'd7;
    localparam logic [3:0] KIND_LITEACK  = 4'd8;
    localparam logic [3:0] KIND_RTS      = 4'd9;
    localparam logic [3:0] KIND_LITEPULL = 4'd10;

    // Classes
    localparam logic CLASS_LOW  = 1'b0;
    localparam logic CLASS_HIGH = 1'b1;

    // Service codes
    localparam logic [1:0] SERVE_NONE = 2'd0;
    localparam logic [1:0] SERVE_LOW  = 2'd1;
    localparam logic [1:0] SERVE_HIGH = 2'd2;

    typedef enum logic [2:0] {
        EV_NONE     = 3'd0,
        EV_ENQUEUED = 3'd1,
        EV_DROPPED  = 3'd2,
        EV_REPLACED = 3'd3,
        EV_DEPARTED = 3'd4,
        EV_ERROR    = 3'd5
    } event_t;

    // Classified item handed from front to back
    typedef struct packed {
        logic               cmd;
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] bytes;
        logic               cls;
        logic               unknown;
        logic               coin;
    } item_t;

    // One result
    typedef struct packed {
        event_t             ev;
        logic [ID_W-1:0]    id;
        logic [BYTES_W-1:0] bytes;
        logic               cls;
        logic [1:0]         serving;
        logic [DROP_W-1:0]  drops;
    } result_t;

endpackage

### rtl/tcpq_front.sv
// ----------------------------------------------------------------------------
// tcpq_front
// Accepts items, classes them by packet kind and holds them in a short queue.
// ----------------------------------------------------------------------------
module tcpq_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          in_cmd,
    input  logic [tcpq_pkg::ID_W-1:0]     in_id,
    input  logic [tcpq_pkg::BYTES_W-1:0]  in_bytes,
    input  logic [3:0]                    in_kind,
    input  logic                          in_hdr,
    input  logic                          in_coin,
    output logic                          q_valid,
    input  logic                          q_pop,
    output tcpq_pkg::item_t               q_item
);
    import tcpq_pkg::*;

    localparam int PW = (FQ_DEPTH > 1) ? $clog2(FQ_DEPTH) : 1;
    localparam int NW = $clog2(FQ_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(FQ_DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT = NW'(FQ_DEPTH);

    item_t         fifo_reg [FQ_DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    item_t         cls_item;
    logic          push;

    // Class the arrival
    always_comb
    begin
        cls_item.cmd     = in_cmd;
        cls_item.id      = in_id;
        cls_item.bytes   = in_bytes;
        cls_item.coin    = in_coin;
        cls_item.unknown = (in_kind > KIND_LITEPULL);
        case (in_kind)
            KIND_TCP, KIND_IP, KIND_LITE: cls_item.cls = CLASS_LOW;
            KIND_TRIM:                    cls_item.cls = in_hdr;
            default:                      cls_item.cls = CLASS_HIGH;
        endcase
    end

    assign in_ready = (cnt_reg != FULL_CNT);
    assign push     = in_valid && in_ready;
    assign q_valid  = (cnt_reg != '0);
    assign q_item   = fifo_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (q_pop && q_valid)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, q_pop && q_valid})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_reg[wr_ptr_reg] <= cls_item;
        end
    end

endmodule

### rtl/tcpq_back.sv
// ----------------------------------------------------------------------------
// tcpq_back
// Descriptor stores, byte totals and service selection; one result per item.
// ----------------------------------------------------------------------------
module tcpq_back
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [tcpq_pkg::TOTAL_W-1:0]  limit,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  tcpq_pkg::item_t               q_item,
    output logic                          res_valid,
    input  logic                          res_ready,
    output tcpq_pkg::result_t             res
);
    import tcpq_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CW:0]   QD_W   = (CW+1)'(QUEUE_DEPTH);
    localparam logic [CW-1:0] FULL_C = CW'(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } state_t;

    state_t              st_reg, st_next;
    item_t               cur_reg;
    logic [AW-1:0]       head_reg  [2];
    logic [AW-1:0]       head_next [2];
    logic [CW-1:0]       fill_reg  [2];
    logic [CW-1:0]       fill_next [2];
    logic [TOTAL_W-1:0]  total_reg  [2];
    logic [TOTAL_W-1:0]  total_next [2];
    logic [1:0]          svc_reg, svc_next;
    logic [DROP_W-1:0]   drop_reg, drop_next;
    result_t             res_reg, res_next;
    logic                res_valid_reg;

    logic [ENTRY_W-1:0]  mem [2**(AW+1)];
    logic [ENTRY_W-1:0]  rd_data_reg;
    logic [AW:0]         rd_addr, rd_addr_reg;
    logic [AW:0]         wr_addr;
    logic [ENTRY_W-1:0]  wr_data;
    logic                wr_en;

    logic                out_free, commit;
    logic                rc, c;
    logic [BYTES_W-1:0]  e_bytes;
    logic [ID_W-1:0]     e_id;
    logic [TOTAL_W:0]    sum_total, rest_sum;
    logic [TOTAL_W-1:0]  rest;

    function automatic logic [AW-1:0] wrap_idx(input logic [CW:0] s);
        if (s >= QD_W)
        begin
            return AW'(s - QD_W);
        end
        return AW'(s);
    endfunction

    function automatic logic [AW-1:0] newest_idx(input logic [AW-1:0] h,
                                                 input logic [CW-1:0] f);
        if (f == '0)
        begin
            return h;
        end
        return wrap_idx((CW+1)'(h) + (CW+1)'(f) - 1'b1);
    endfunction

    assign out_free  = !res_valid_reg || res_ready;
    assign commit    = (st_reg == S_EXEC) && out_free;
    assign q_pop     = (st_reg == S_IDLE) && q_valid;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    // Read address: head of the class in service, or newest of the arrival class
    always_comb
    begin
        if (q_item.cmd == CMD_COMPLETE)
        begin
            rc      = (svc_reg == SERVE_HIGH);
            rd_addr = {rc, head_reg[rc]};
        end
        else
        begin
            rc      = q_item.cls;
            rd_addr = {rc, newest_idx(head_reg[rc], fill_reg[rc])};
        end
    end

    assign e_bytes = rd_data_reg[BYTES_W-1:0];
    assign e_id    = rd_data_reg[ENTRY_W-1:BYTES_W];

    always_comb
    begin
        st_next       = st_reg;
        head_next     = head_reg;
        fill_next     = fill_reg;
        total_next    = total_reg;
        svc_next      = svc_reg;
        drop_next     = drop_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = rd_addr_reg;
        wr_data       = {cur_reg.id, cur_reg.bytes};
        c             = cur_reg.cls;
        sum_total     = '0;
        rest          = '0;
        rest_sum      = '0;

        case (st_reg)
            S_IDLE:
            begin
                if (q_valid)
                begin
                    st_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                res_next.ev    = EV_NONE;
                res_next.id    = cur_reg.id;
                res_next.bytes = cur_reg.bytes;
                res_next.cls   = CLASS_LOW;
                if (cur_reg.cmd == CMD_COMPLETE)
                begin
                    c = (svc_reg == SERVE_HIGH);
                    if (svc_reg == SERVE_NONE)
                    begin
                        res_next.ev    = EV_ERROR;
                        res_next.id    = '0;
                        res_next.bytes = '0;
                    end
                    else
                    begin
                        // Send out the head entry and advance
                        head_next[c]   = wrap_idx((CW+1)'(head_reg[c]) + 1'b1);
                        fill_next[c]   = fill_reg[c] - 1'b1;
                        total_next[c]  = (total_reg[c] >= TOTAL_W'(e_bytes)) ?
                                         total_reg[c] - TOTAL_W'(e_bytes) : '0;
                        res_next.ev    = EV_DEPARTED;
                        res_next.id    = e_id;
                        res_next.bytes = e_bytes;
                        res_next.cls   = c;
                        if (fill_next[CLASS_HIGH] != '0)
                            svc_next = SERVE_HIGH;
                        else if (fill_next[CLASS_LOW] != '0)
                            svc_next = SERVE_LOW;
                        else
                            svc_next = SERVE_NONE;
                    end
                end
                else if (cur_reg.unknown)
                begin
                    res_next.ev = EV_ERROR;
                end
                else
                begin
                    res_next.cls = c;
                    sum_total = {1'b0, total_reg[c]} + (TOTAL_W+1)'(cur_reg.bytes);
                    rest      = (total_reg[c] >= TOTAL_W'(e_bytes)) ?
                                total_reg[c] - TOTAL_W'(e_bytes) : '0;
                    rest_sum  = {1'b0, rest} + (TOTAL_W+1)'(cur_reg.bytes);
                    if (sum_total > {1'b0, limit})
                    begin
                        res_next.ev = EV_DROPPED;
                        if (cur_reg.coin && (fill_reg[c] != '0) &&
                            (rest_sum <= {1'b0, TOTAL_MAX}))
                        begin
                            // Replace the newest entry with the arrival
                            wr_en          = 1'b1;
                            wr_addr        = rd_addr_reg;
                            total_next[c]  = rest_sum[TOTAL_W-1:0];
                            res_next.ev    = EV_REPLACED;
                            res_next.id    = e_id;
                            res_next.bytes = e_bytes;
                        end
                        if (drop_reg != '1)
                        begin
                            drop_next = drop_reg + 1'b1;
                        end
                    end
                    else if (fill_reg[c] == FULL_C)
                    begin
                        res_next.ev = EV_ERROR;
                    end
                    else
                    begin
                        wr_en         = 1'b1;
                        wr_addr       = {c, wrap_idx((CW+1)'(head_reg[c]) +
                                                     (CW+1)'(fill_reg[c]))};
                        fill_next[c]  = fill_reg[c] + 1'b1;
                        total_next[c] = sum_total[TOTAL_W-1:0];
                        res_next.ev   = EV_ENQUEUED;
                    end
                    if (svc_reg == SERVE_NONE)
                    begin
                        if (fill_next[CLASS_HIGH] != '0)
                            svc_next = SERVE_HIGH;
                        else if (fill_next[CLASS_LOW] != '0)
                            svc_next = SERVE_LOW;
                        else
                            svc_next = SERVE_NONE;
                    end
                end
                res_next.serving = svc_next;
                res_next.drops   = drop_next;
                if (out_free)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= S_IDLE;
            head_reg[0]   <= '0;
            head_reg[1]   <= '0;
            fill_reg[0]   <= '0;
            fill_reg[1]   <= '0;
            total_reg[0]  <= '0;
            total_reg[1]  <= '0;
            svc_reg       <= SERVE_NONE;
            drop_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (commit)
            begin
                head_reg      <= head_next;
                fill_reg      <= fill_next;
                total_reg     <= total_next;
                svc_reg       <= svc_next;
                drop_reg      <= drop_next;
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg     <= q_item;
            rd_addr_reg <= rd_addr;
        end
        if (commit)
        begin
            res_reg <= res_next;
        end
    end

    // Descriptor memory: both classes, class bit on top of the address.
    // Hold the read entry for the whole execution step, stalls included.
    always_ff @(posedge clk)
    begin
        if (commit && wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (q_pop)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg[0] <= FULL_C) && (fill_reg[1] <= FULL_C))
        else $error("class fill beyond depth");

    a_none_empty: assert property (@(posedge clk) disable iff (!rst_n)
        (svc_reg == SERVE_NONE) == ((fill_reg[0] == '0) && (fill_reg[1] == '0)))
        else $error("service state disagrees with queue fill");

    a_serve_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        ((svc_reg == SERVE_HIGH) |-> (fill_reg[1] != '0)) and
        ((svc_reg == SERVE_LOW)  |-> (fill_reg[0] != '0)))
        else $error("class in service is empty");

    a_pop_exec: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |=> (st_reg == S_EXEC))
        else $error("item taken without execution step");

endmodule

### rtl/two_class_priority_packet_queue.sv
// ----------------------------------------------------------------------------
// two_class_priority_packet_queue
// Strict-priority descriptor queue with a high and a low class and byte limits.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Content
//  s_*       in         s_tvalid / s_tready    packet arrival or serve complete
//  m_*       out        m_tvalid / m_tready    one event per accepted item
//  APB       in         psel & penable         max_queue_bytes at address 0
//
//  In the back end each item is taken in S_IDLE, which reads the descriptor
//  memory (head or newest entry), then S_EXEC updates it and the per-class state.
//  The front queue holds two classified items, so up to two items are taken
//  while the back end works or a result waits for m_tready; then s_tready drops.
//  Reset clears counts, totals, service and drop count; descriptor memory
//  contents are not cleared and need no clearing pass.
//  A stalled result holds in the output register; the back end waits on it.
// ----------------------------------------------------------------------------
module two_class_priority_packet_queue
#(
    parameter int QUEUE_DEPTH = 64
)
(
    input  logic        clk,
    input  logic        rst_n,
    // APB configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    // [15:0] packet_id, [29:16] packet_bytes, [33:30] packet_kind,
    // [34] trimmed header flag, [35] drop_coin, [39:36] zero
    input  logic [39:0] s_tdata,
    // [0] command
    input  logic [0:0]  s_tuser,
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    // [15:0] out_id, [29:16] out_bytes, [30] out_class, [32:31] serving,
    // [64:33] drop_total, [71:65] zero
    output logic [71:0] m_tdata,
    // [2:0] event_kind
    output logic [2:0]  m_tuser
);
    import tcpq_pkg::*;

    logic [TOTAL_W-1:0] limit_reg;
    logic               q_valid, q_pop;
    item_t              q_item;
    result_t            res;
    logic               cfg_wr;

    // Register file: one register, decoded on paddr[2]
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && !paddr[2];
    assign prdata = paddr[2] ? 32'd0 : {8'd0, limit_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_wr)
        begin
            limit_reg <= pwdata[TOTAL_W-1:0];
        end
    end

    // Front: accept and class items
    tcpq_front u_front
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .in_cmd   (s_tuser[0]),
        .in_id    (s_tdata[15:0]),
        .in_bytes (s_tdata[29:16]),
        .in_kind  (s_tdata[33:30]),
        .in_hdr   (s_tdata[34]),
        .in_coin  (s_tdata[35]),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_item   (q_item)
    );

    // Back: stores, totals, service selection and result register
    tcpq_back #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .limit     (limit_reg),
        .q_valid   (q_valid),
        .q_pop     (q_pop),
        .q_item    (q_item),
        .res_valid (m_tvalid),
        .res_ready (m_tready),
        .res       (res)
    );

    // Pack the result
    assign m_tuser = res.ev;
    assign m_tdata = {7'd0, res.drops, res.serving, res.cls, res.bytes, res.id};

endmodule

### tb/tcpq_event_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcpq_event_checker
// Watches the item and event streams and the APB port of the two-class
// priority packet queue, predicts each event from its own copy of the
// queue state, and compares every delivered event field by field.
// ----------------------------------------------------------------------------
module tcpq_event_checker
#(
    parameter int         QUEUE_DEPTH = 64,
    parameter logic [2:0] LIMIT_ADDR  = 3'd0
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [39:0] s_tdata,
    input  logic [0:0]  s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [71:0] m_tdata,
    input  logic [2:0]  m_tuser,
    output int          fail_count,
    output int          pending
);
    import tcpq_pkg::*;

    logic [ID_W-1:0]    desc_id    [2][QUEUE_DEPTH];
    logic [BYTES_W-1:0] desc_bytes [2][QUEUE_DEPTH];
    int                 desc_head  [2];
    int                 desc_fill  [2];
    logic [25:0]        class_total[2];
    logic [1:0]         serve_sel;
    logic [DROP_W-1:0]  drop_count;
    logic [TOTAL_W-1:0] byte_limit;

    result_t expected_events[$];

    function automatic logic class_of(logic [3:0] kind, logic hdr);
        if (kind == KIND_TCP || kind == KIND_IP || kind == KIND_LITE)
            return CLASS_LOW;
        if (kind == KIND_TRIM)
            return hdr ? CLASS_HIGH : CLASS_LOW;
        return CLASS_HIGH;
    endfunction

    function automatic void pick_service();
        if (desc_fill[CLASS_HIGH] != 0)
            serve_sel = SERVE_HIGH;
        else if (desc_fill[CLASS_LOW] != 0)
            serve_sel = SERVE_LOW;
        else
            serve_sel = SERVE_NONE;
    endfunction

    function automatic result_t predict_event(logic cmd, logic [ID_W-1:0] id,
                                              logic [BYTES_W-1:0] nbytes,
                                              logic [3:0] kind, logic hdr,
                                              logic coin);
        result_t     r;
        logic        c;
        int          slot;
        logic [25:0] rest;
        r = '0;
        if (cmd == CMD_COMPLETE)
        begin
            if (serve_sel == SERVE_NONE)
            begin
                r.ev = EV_ERROR;
            end
            else
            begin
                c = (serve_sel == SERVE_HIGH) ? CLASS_HIGH : CLASS_LOW;
                r.id    = desc_id[c][desc_head[c]];
                r.bytes = desc_bytes[c][desc_head[c]];
                r.cls   = c;
                r.ev    = EV_DEPARTED;
                desc_head[c] = (desc_head[c] + 1) % QUEUE_DEPTH;
                desc_fill[c] = desc_fill[c] - 1;
                class_total[c] = (class_total[c] >= r.bytes) ?
                                 class_total[c] - r.bytes : '0;
                serve_sel = SERVE_NONE;
                pick_service();
            end
        end
        else if (kind > KIND_LITEPULL)
        begin
            // unknown kind: flag it, touch nothing
            r.ev    = EV_ERROR;
            r.id    = id;
            r.bytes = nbytes;
        end
        else
        begin
            c = class_of(kind, hdr);
            r.cls   = c;
            r.id    = id;
            r.bytes = nbytes;
            if (class_total[c] + nbytes > byte_limit)
            begin
                r.ev = EV_DROPPED;
                if (coin && desc_fill[c] != 0)
                begin
                    slot = (desc_head[c] + desc_fill[c] - 1) % QUEUE_DEPTH;
                    rest = (class_total[c] >= desc_bytes[c][slot]) ?
                           class_total[c] - desc_bytes[c][slot] : '0;
                    if (rest + nbytes <= TOTAL_MAX)
                    begin
                        r.ev    = EV_REPLACED;
                        r.id    = desc_id[c][slot];
                        r.bytes = desc_bytes[c][slot];
                        desc_id[c][slot]    = id;
                        desc_bytes[c][slot] = nbytes;
                        class_total[c]      = rest + nbytes;
                    end
                end
                if (drop_count != '1)
                    drop_count = drop_count + 1'b1;
            end
            else if (desc_fill[c] >= QUEUE_DEPTH)
            begin
                r.ev = EV_ERROR;
            end
            else
            begin
                slot = (desc_head[c] + desc_fill[c]) % QUEUE_DEPTH;
                desc_id[c][slot]    = id;
                desc_bytes[c][slot] = nbytes;
                desc_fill[c]        = desc_fill[c] + 1;
                class_total[c]      = class_total[c] + nbytes;
                r.ev = EV_ENQUEUED;
            end
            if (serve_sel == SERVE_NONE)
                pick_service();
        end
        r.serving = serve_sel;
        r.drops   = drop_count;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name,
                     want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            for (int k = 0; k < 2; k++)
            begin
                desc_head[k]   = 0;
                desc_fill[k]   = 0;
                class_total[k] = '0;
            end
            serve_sel  = SERVE_NONE;
            drop_count = '0;
            byte_limit = LIMIT_RESET;
            expected_events.delete();
            pending    = 0;
            fail_count = 0;
        end
        else
        begin
            // events first: one delivered on the same edge as a new item
            // always belongs to an older item
            if (m_tvalid && m_tready)
            begin
                if (expected_events.size() == 0)
                begin
                    $display("%0t: unexpected event, actual kind %0h data %0h",
                             $time, m_tuser, m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_events[0];
                    expected_events.delete(0);
                    check_field("event_kind", want.ev, m_tuser);
                    check_field("out_id", want.id, m_tdata[15:0]);
                    check_field("out_bytes", want.bytes, m_tdata[29:16]);
                    check_field("out_class", want.cls, m_tdata[30]);
                    check_field("serving", want.serving, m_tdata[32:31]);
                    check_field("drop_total", want.drops, m_tdata[64:33]);
                end
            end
            if (s_tvalid && s_tready)
                expected_events.push_back(predict_event(s_tuser[0], s_tdata[15:0],
                                                        s_tdata[29:16],
                                                        s_tdata[33:30],
                                                        s_tdata[34], s_tdata[35]));
            if (psel && penable && pready && paddr == LIMIT_ADDR)
            begin
                if (pwrite)
                    byte_limit = pwdata[TOTAL_W-1:0];
                else
                    check_field("max_queue_bytes", {8'h00, byte_limit}, prdata);
            end
            pending = expected_events.size();
        end
    end

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus and verdict for the two-class priority packet queue: directed
// arrivals, completes and overflow cases, then random phases over several
// byte limits with random idling on both streams.
// ----------------------------------------------------------------------------
module tb_top;
    import tcpq_pkg::*;

    localparam int         QUEUE_DEPTH      = 64;
    localparam logic [2:0] REG_MAX_BYTES    = 3'd0;
    localparam logic [3:0] KIND_UNKNOWN_LO  = 4'd11;
    localparam logic [3:0] KIND_UNKNOWN_HI  = 4'd15;
    localparam int         ITEMS_PER_PHASE  = 95;
    // settle time after the last event, covering the front queue and the back end
    localparam int         SETTLE_CYCLES    = 12;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;
    logic [0:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic [2:0]  m_tuser;

    int fail_count;
    int pending;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    always #6 clk = ~clk;

    two_class_priority_packet_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    tcpq_event_checker #(.QUEUE_DEPTH(QUEUE_DEPTH), .LIMIT_ADDR(REG_MAX_BYTES)) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Receiver: drop tready at random, one decision per falling edge.
    always @(negedge clk)
        m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);

    // Offer one item; idle first at random, then hold it until accepted.
    // Returns just after the accepting edge with tvalid still high.
    task automatic send_item(input logic cmd, input logic [ID_W-1:0] id,
                             input logic [BYTES_W-1:0] nbytes, input logic [3:0] kind,
                             input logic hdr, input logic coin);
        @(negedge clk);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {4'h0, coin, hdr, kind, nbytes, id};
        s_tuser  <= cmd;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic send_arrival(input logic [ID_W-1:0] id, input logic [BYTES_W-1:0] nbytes,
                                input logic [3:0] kind, input logic hdr, input logic coin);
        send_item(CMD_ARRIVE, id, nbytes, kind, hdr, coin);
    endtask

    // Complete: only the command matters, scramble the rest anyway.
    task automatic send_complete();
        send_item(CMD_COMPLETE, ID_W'($urandom), BYTES_W'($urandom), 4'($urandom),
                  1'($urandom), 1'($urandom));
    endtask

    // Mostly small packets so byte limits bite gradually; a few of any size.
    task automatic send_random(input int arrive_pct, input int big_pct);
        logic [BYTES_W-1:0] nbytes;
        logic [3:0]         kind;
        int                 pick;
        if ($urandom_range(0, 99) >= arrive_pct)
        begin
            send_complete();
        end
        else
        begin
            pick = $urandom_range(0, 99);
            if (pick < big_pct)
                nbytes = BYTES_W'($urandom);
            else if (pick < big_pct + 20)
                nbytes = BYTES_W'($urandom_range(0, 4000));
            else
                nbytes = BYTES_W'($urandom_range(0, 300));
            if ($urandom_range(0, 99) < 8)
                kind = 4'($urandom_range(KIND_UNKNOWN_LO, KIND_UNKNOWN_HI));
            else
                kind = 4'($urandom_range(KIND_TCP, KIND_LITEPULL));
            send_arrival(ID_W'($urandom), nbytes, kind, 1'($urandom), 1'($urandom));
        end
    endtask

    // Hold the sender until every event is out, then let the block settle.
    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic apb_access(input logic wr, input logic [2:0] addr, input logic [31:0] data);
        @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Change the limit while idle, read it back, then run random items.
    task automatic run_phase(input logic [31:0] limit_word, input int s_pct, input int m_pct,
                             input int arrive_pct, input int big_pct);
        wait_drained();
        apb_access(1'b1, REG_MAX_BYTES, limit_word);
        apb_access(1'b0, REG_MAX_BYTES, '0);
        send_idle_pct = s_pct;
        recv_idle_pct = m_pct;
        repeat (ITEMS_PER_PHASE) send_random(arrive_pct, big_pct);
    endtask

    initial
    begin
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Check the reset limit, then shrink it so the directed items overflow.
        apb_access(1'b0, REG_MAX_BYTES, '0);
        apb_access(1'b1, REG_MAX_BYTES, 32'd100);
        send_idle_pct = 12;
        recv_idle_pct = 55;

        // complete with nothing in service, unknown kinds at both ends
        send_complete();
        send_arrival(16'hFFFF, 14'h3FFF, KIND_UNKNOWN_HI, 1'b1, 1'b1);
        send_arrival(16'h0000, 14'h0000, KIND_UNKNOWN_LO, 1'b0, 1'b0);
        // replace on an empty class falls back to dropping the arrival
        send_arrival(16'h1234, 14'h3FFF, KIND_TCP, 1'b0, 1'b1);
        // low class fills to the limit: one drop, and an arrival with the coin set still fits and is queued
        send_arrival(16'h0000, 14'h0000, KIND_TCP, 1'b0, 1'b0);
        send_arrival(16'hFFFF, 14'd60, KIND_IP, 1'b1, 1'b0);
        send_arrival(16'hA5A5, 14'd50, KIND_LITE, 1'b0, 1'b0);
        send_arrival(16'h5A5A, 14'd30, KIND_LITE, 1'b1, 1'b1);
        send_arrival(16'h0101, 14'd10, KIND_TRIM, 1'b0, 1'b0);
        // every high kind; service stays on the low class already chosen
        send_arrival(16'h0202, 14'd20, KIND_TRIM, 1'b1, 1'b0);
        send_arrival(16'h0303, 14'd10, KIND_TCPACK, 1'b0, 1'b0);
        send_arrival(16'h0404, 14'd10, KIND_ACK, 1'b0, 1'b0);
        send_arrival(16'h0505, 14'd10, KIND_NACK, 1'b0, 1'b0);
        send_arrival(16'h0606, 14'd10, KIND_PULL, 1'b0, 1'b0);
        send_arrival(16'h0707, 14'd10, KIND_LITEACK, 1'b0, 1'b0);
        send_arrival(16'h0808, 14'd10, KIND_RTS, 1'b0, 1'b0);
        send_arrival(16'h0909, 14'd10, KIND_LITEPULL, 1'b0, 1'b0);
        // a huge replacement pushes the high total far past the limit
        send_arrival(16'hBEEF, 14'h3FFF, KIND_ACK, 1'b0, 1'b1);
        send_complete();
        send_complete();
        // even a zero-byte arrival drops while the class is over its limit
        send_arrival(16'hCAFE, 14'd0, KIND_PULL, 1'b0, 1'b0);
        send_complete();
        send_complete();

        // Random phases: reset limit, widest limit to fill the descriptor
        // store, zero limit written with junk in the upper bits, then mid values.
        run_phase({8'h00, LIMIT_RESET}, 12, 55, 60, 5);
        run_phase(32'h00FF_FFFF, 12, 55, 92, 0);
        run_phase(32'hFF00_0000, 55, 12, 55, 10);
        run_phase($urandom_range(2000, 30000), 55, 12, 55, 10);
        run_phase(32'd5000, 0, 0, 55, 5);
        // pause the sender until everything is out, then carry on
        wait_drained();
        repeat (ITEMS_PER_PHASE / 2) send_random(55, 5);

        wait_drained();
        if (fail_count == 0)
            $display("two_class_priority_packet_queue test passed");
        else
            $display("two_class_priority_packet_queue test failed");
        $finish;
    end

    // Watchdog: far beyond the slowest correct run.
    initial
    begin
        #5_000_000;
        $display("two_class_priority_packet_queue test failed");
        $finish;
    end

endmodule
